FILE: hdl/http_chunked_body_decoder_core_assert.svh
// Assertion macros for the chunked body decoder.
// HCBD_ASSERT checks a property outside reset; HCBD_ASSERT_ALWAYS checks it at every edge.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HCBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

  localparam int unsigned SIZE_BITS_DEF       = 32;
  localparam int unsigned MAX_SIZE_DIGITS_DEF = 8;
  localparam logic [31:0] MAX_BODY_RST        = 32'd1048576;

  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // decoder phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SIZE    = 3'd1;
  localparam logic [2:0] PH_SIZE_LF = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_DATA_CR = 3'd4;
  localparam logic [2:0] PH_DATA_LF = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_FRAMING = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // error causes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EMPTY_SIZE = 3'd1;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
  localparam logic [2:0] ERR_BUDGET     = 3'd4;
  localparam logic [2:0] ERR_NO_CRLF    = 3'd5;

  typedef struct packed {
    logic [2:0] phase;
    logic       last_zero;
    logic [2:0] err_code;
  } ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
    logic       chunk_end;
    logic [2:0] error_cause;
  } res_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] l;
    begin
      l = c | CASE_BIT;
      if (c >= 8'h30 && c <= 8'h39) begin
        hex_decode = {1'b1, c[3:0]};
      end else if (l >= 8'h61 && l <= 8'h66) begin
        hex_decode = {1'b1, 4'(l - 8'h57)};
      end else begin
        hex_decode = 5'd0;
      end
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hcbd_if.sv
`default_nettype none
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       body_start;
  modport source (output valid, output data_byte, output body_start, input ready);
  modport sink (input valid, input data_byte, input body_start, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;
  logic       chunk_end;
  logic [2:0] error_cause;
  modport source (output valid, output kind, output payload, output chunk_end,
                  output error_cause, input ready);
  modport sink (input valid, input kind, input payload, input chunk_end,
                input error_cause, output ready);
endinterface

interface hcbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_body_size;
  modport source (output valid, output max_body_size, input ready);
  modport sink (input valid, input max_body_size, output ready);
endinterface
`default_nettype wire

FILE: hdl/http_chunked_body_decoder_core.sv
// Chunked body decoder: one byte of an HTTP/1.1 chunked body per item, one result item
// per byte. Throughput is one byte per clock unless the output stalls; the result enters
// the output register in the cycle after its byte is accepted. The byte decode and the
// decoder state update happen in the same cycle, so a new byte is taken every clock as long
// as the output register is empty or being drained in the same cycle (in_ch.ready follows
// out_ch.ready when a result is waiting). cfg_ch is always ready; write max_body_size only while idle.
`default_nettype none
`include "http_chunked_body_decoder_core_assert.svh"
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_BITS       = hcbd_pkg::SIZE_BITS_DEF,
  parameter int unsigned MAX_SIZE_DIGITS = hcbd_pkg::MAX_SIZE_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hcbd_in_if.sink    in_ch,
  hcbd_out_if.source out_ch,
  hcbd_cfg_if.sink   cfg_ch
);
  import hcbd_pkg::*;

  localparam int unsigned DW = $clog2(MAX_SIZE_DIGITS + 1);

  ctl_t                 ctl_r, ctl_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [DW-1:0]        digits_r, digits_nxt;
  logic [SIZE_BITS-1:0] data_left_r, data_left_nxt;
  logic [31:0]          budget_r, budget_nxt;
  logic [31:0]          max_body_r;
  res_t                 res_r, res_nxt;
  logic                 out_valid_r;
  logic                 in_acc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  hcbd_step #(
    .SIZE_BITS       (SIZE_BITS),
    .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS),
    .DW              (DW)
  ) u_step (
    .ctl_i       (ctl_r),
    .acc_i       (acc_r),
    .digits_i    (digits_r),
    .data_left_i (data_left_r),
    .budget_i    (budget_r),
    .max_body_i  (max_body_r),
    .data_byte   (in_ch.data_byte),
    .body_start  (in_ch.body_start),
    .ctl_o       (ctl_nxt),
    .acc_o       (acc_nxt),
    .digits_o    (digits_nxt),
    .data_left_o (data_left_nxt),
    .budget_o    (budget_nxt),
    .res_o       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '{phase: PH_IDLE, last_zero: 1'b0, err_code: ERR_NONE};
      out_valid_r <= 1'b0;
      max_body_r  <= MAX_BODY_RST;
    end else begin
      if (cfg_ch.valid) begin
        max_body_r <= cfg_ch.max_body_size;
      end
      if (in_acc) begin
        ctl_r       <= ctl_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r       <= acc_nxt;
      digits_r    <= digits_nxt;
      data_left_r <= data_left_nxt;
      budget_r    <= budget_nxt;
      res_r       <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.payload     = res_r.payload;
  assign out_ch.chunk_end   = res_r.chunk_end;
  assign out_ch.error_cause = res_r.error_cause;

  `HCBD_ASSERT(a_start_enters_size, clk, rst_n, (in_acc && in_ch.body_start) |=> (ctl_r.phase == PH_SIZE || ctl_r.phase == PH_SIZE_LF || ctl_r.phase == PH_ERROR), "start byte did not enter size line")
  `HCBD_ASSERT(a_err_sticky, clk, rst_n, (out_valid_r && res_r.kind == KIND_ERROR) |-> (ctl_r.phase == PH_ERROR), "error result without error phase")
  `HCBD_ASSERT(a_chunk_end_phase, clk, rst_n, (out_valid_r && res_r.kind == KIND_PAYLOAD && res_r.chunk_end) |-> (ctl_r.phase == PH_DATA_CR), "chunk end not followed by CRLF check")
  `HCBD_ASSERT(a_data_nonzero, clk, rst_n, (ctl_r.phase == PH_DATA) |-> (data_left_r != '0), "data phase with no bytes left")

endmodule
`default_nettype wire

FILE: hdl/hcbd_step.sv
`default_nettype none
module hcbd_step #(
  parameter int unsigned SIZE_BITS       = 32,
  parameter int unsigned MAX_SIZE_DIGITS = 8,
  parameter int unsigned DW              = $clog2(MAX_SIZE_DIGITS + 1)
) (
  input  hcbd_pkg::ctl_t        ctl_i,
  input  logic [SIZE_BITS-1:0]  acc_i,
  input  logic [DW-1:0]         digits_i,
  input  logic [SIZE_BITS-1:0]  data_left_i,
  input  logic [31:0]           budget_i,
  input  logic [31:0]           max_body_i,
  input  logic [7:0]            data_byte,
  input  logic                  body_start,
  output hcbd_pkg::ctl_t        ctl_o,
  output logic [SIZE_BITS-1:0]  acc_o,
  output logic [DW-1:0]         digits_o,
  output logic [SIZE_BITS-1:0]  data_left_o,
  output logic [31:0]           budget_o,
  output hcbd_pkg::res_t        res_o
);
  import hcbd_pkg::*;

  localparam int unsigned CW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  ctl_t                 ctl;
  logic [SIZE_BITS-1:0] acc;
  logic [DW-1:0]        digits;
  logic [SIZE_BITS-1:0] data_left;
  logic [SIZE_BITS-1:0] dl_dec;
  logic [31:0]          budget;
  logic [4:0]           hex;
  logic [CW-1:0]        acc_w;
  logic [CW-1:0]        bud_w;
  logic                 fail;
  logic [2:0]           fail_cause;

  always_comb begin
    ctl       = ctl_i;
    acc       = acc_i;
    digits    = digits_i;
    data_left = data_left_i;
    budget    = budget_i;
    // start mark reloads everything before the byte is decoded
    if (body_start) begin
      ctl.phase     = PH_SIZE;
      ctl.last_zero = 1'b0;
      ctl.err_code  = ERR_NONE;
      acc           = '0;
      digits        = '0;
      data_left     = '0;
      budget        = max_body_i;
    end

    hex        = hex_decode(data_byte);
    acc_w      = CW'(acc);
    bud_w      = CW'(budget);
    dl_dec     = (data_left != '0) ? data_left - SIZE_BITS'(1) : data_left;
    fail       = 1'b0;
    fail_cause = ERR_NONE;

    ctl_o       = ctl;
    acc_o       = acc;
    digits_o    = digits;
    data_left_o = data_left;
    budget_o    = budget;
    res_o       = '0;

    case (ctl.phase)
      PH_SIZE: begin
        if (data_byte == BYTE_CR) begin
          ctl_o.phase = PH_SIZE_LF;
        end else if (!hex[4]) begin
          fail = 1'b1; fail_cause = ERR_BAD_CHAR;
        end else if (digits >= DW'(MAX_SIZE_DIGITS)) begin
          fail = 1'b1; fail_cause = ERR_TOO_LONG;
        end else if (|acc[SIZE_BITS-1 -: 4]) begin
          // next shift would lose bits
          fail = 1'b1; fail_cause = ERR_TOO_LONG;
        end else begin
          acc_o    = {acc[SIZE_BITS-5:0], hex[3:0]};
          digits_o = digits + DW'(1);
        end
      end
      PH_SIZE_LF: begin
        if (data_byte != BYTE_LF) begin
          fail = 1'b1; fail_cause = ERR_BAD_CHAR;
        end else if (digits == '0) begin
          fail = 1'b1; fail_cause = ERR_EMPTY_SIZE;
        end else if (acc_w > bud_w) begin
          fail = 1'b1; fail_cause = ERR_BUDGET;
        end else begin
          budget_o    = 32'(bud_w - acc_w);
          data_left_o = acc;
          if (acc == '0) begin
            ctl_o.last_zero = 1'b1;
            ctl_o.phase     = PH_DATA_CR;
          end else begin
            ctl_o.phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_o.kind      = KIND_PAYLOAD;
        res_o.payload   = data_byte;
        res_o.chunk_end = (data_left <= SIZE_BITS'(1));
        data_left_o     = dl_dec;
        if (dl_dec == '0) begin
          ctl_o.phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (data_byte != BYTE_CR) begin
          fail = 1'b1; fail_cause = ERR_NO_CRLF;
        end else begin
          ctl_o.phase = PH_DATA_LF;
        end
      end
      PH_DATA_LF: begin
        if (data_byte != BYTE_LF) begin
          fail = 1'b1; fail_cause = ERR_NO_CRLF;
        end else if (ctl.last_zero) begin
          ctl_o.phase = PH_DONE;
          res_o.kind  = KIND_DONE;
        end else begin
          acc_o       = '0;
          digits_o    = '0;
          ctl_o.phase = PH_SIZE;
        end
      end
      PH_ERROR: begin
        res_o.kind        = KIND_ERROR;
        res_o.error_cause = ctl.err_code;
      end
      default: begin
      end
    endcase

    if (fail) begin
      ctl_o.phase       = PH_ERROR;
      ctl_o.err_code    = fail_cause;
      res_o             = '0;
      res_o.kind        = KIND_ERROR;
      res_o.error_cause = fail_cause;
    end
  end

endmodule
`default_nettype wire
